// ----- hw/rtl/nearest_point_distance_sum_top_assert.svh -----
// Assertion macros for the nearest point distance sum block.
`ifndef NEAREST_POINT_DISTANCE_SUM_TOP_ASSERT_SVH
`define NEAREST_POINT_DISTANCE_SUM_TOP_ASSERT_SVH
// Checks that an implication holds at every clock edge outside reset.
`define NPDS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("npds check failed");
// Checks that a condition holds in the cycle after a trigger.
`define NPDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("npds check failed");
`endif

// ----- hw/rtl/npds_pkg.sv -----
// ----------------------------------------------------------------------------
// npds_pkg
// Shared types and constants of the nearest point distance sum block.
// ----------------------------------------------------------------------------
package npds_pkg;
    localparam int SLOT_BITS = 20;
    localparam int REG_BITS  = 60;
    localparam int SQ_BITS   = 43;
    localparam int SUM_BITS  = 27;
    localparam int CRV_BITS  = 5;
    localparam int RT_BITS   = 22;
    localparam int IDX_BITS  = 2;
    localparam logic [SQ_BITS-1:0]  NEAR_INIT = '1;
    localparam logic [SUM_BITS-1:0] BEST_INIT = 27'd25600000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                capture;   // load the incoming point
        logic                update;    // compare distances into minima
        logic                root_start;
        logic                root_step;
        logic                root_acc;  // add the finished root into the sums
        logic [IDX_BITS-1:0] ref_sel;
        logic                finish;    // update bests, clear minima
    } npds_cmd_t;

    typedef struct packed {
        logic root_done;
    } npds_sts_t;
endpackage

// ----- hw/rtl/npds_if.sv -----
// ----------------------------------------------------------------------------
// npds_point_if / npds_result_if / npds_cfg_if
// Valid/ready channels of the block.
// ----------------------------------------------------------------------------
interface npds_point_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] point_x;
    logic signed [19:0] point_y;
    logic signed [19:0] point_z;
    logic [4:0]         curve_number;
    logic               last_point;
    modport source (output valid, point_x, point_y, point_z, curve_number, last_point,
                    input ready);
    modport sink (input valid, point_x, point_y, point_z, curve_number, last_point,
                  output ready);
endinterface

interface npds_result_if;
    logic        valid;
    logic        ready;
    logic [26:0] sum_four;
    logic [26:0] sum_three;
    logic [26:0] sum_two;
    logic [26:0] sum_one;
    logic [26:0] best_four;
    logic [26:0] best_three;
    logic [26:0] best_two;
    logic [26:0] best_one;
    logic [4:0]  best_curve;
    modport source (output valid, sum_four, sum_three, sum_two, sum_one, best_four,
                    best_three, best_two, best_one, best_curve, input ready);
    modport sink (input valid, sum_four, sum_three, sum_two, sum_one, best_four,
                  best_three, best_two, best_one, best_curve, output ready);
endinterface

interface npds_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [59:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/nearest_point_distance_sum_top.sv -----
// Each path point is captured, then compared into the four minima. A
// curve's last point then runs, per reference, the bit-serial square root
// (load, 22 steps, then add into the sums), then closes the curve and
// offers the result; the next point is taken after the result transfer.
// ----------------------------------------------------------------------------
// nearest_point_distance_sum_top
// Nearest reference distances summed per curve, with running bests.
// ----------------------------------------------------------------------------
module nearest_point_distance_sum_top
    import npds_pkg::*;
#(
    parameter int NUM_REFS   = 4,
    parameter int MAX_CURVES = 32,
    parameter int COORD_BITS = 20
)
(
    input logic          clk,
    input logic          rst_n,
    npds_point_if.sink   point,
    npds_result_if.source result,
    npds_cfg_if.sink     cfg
);
    logic [REG_BITS-1:0] ref_reg [4];
    logic [SUM_BITS-1:0] sums [4];
    logic [SUM_BITS-1:0] bests [4];
    logic [CRV_BITS-1:0] best_idx;
    npds_cmd_t           cmd;
    npds_sts_t           sts;

    // Reference point registers.
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 4; r++)
            begin
                ref_reg[r] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            ref_reg[cfg.index] <= cfg.data;
        end
    end

    npds_ctrl #(.NUM_REFS(NUM_REFS), .MAX_CURVES(MAX_CURVES)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(point.valid), .in_ready(point.ready),
        .in_curve(point.curve_number), .in_last(point.last_point),
        .out_valid(result.valid), .out_ready(result.ready),
        .cmd(cmd), .sts(sts)
    );

    npds_dp #(.NUM_REFS(NUM_REFS), .COORD_BITS(COORD_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .ref_pts(ref_reg),
        .px(point.point_x), .py(point.point_y), .pz(point.point_z),
        .curve(point.curve_number), .cmd(cmd), .sts(sts),
        .sums(sums), .bests(bests), .best_idx(best_idx)
    );

    assign result.sum_four   = sums[3];
    assign result.sum_three  = sums[2];
    assign result.sum_two    = sums[1];
    assign result.sum_one    = sums[0];
    assign result.best_four  = bests[3];
    assign result.best_three = bests[2];
    assign result.best_two   = bests[1];
    assign result.best_one   = bests[0];
    assign result.best_curve = best_idx;

`include "nearest_point_distance_sum_top_assert.svh"
    // The block never takes a point while a result is pending.
    `NPDS_ASSERT_IMP(a_no_take_while_out, result.valid, !point.ready)
    // A root is never started and stepped at once.
    `NPDS_ASSERT_IMP(a_root_excl, cmd.root_start, !cmd.root_step)
    // Closing a curve always offers a result next.
    `NPDS_ASSERT_NEXT(a_fin_out, cmd.finish, result.valid)
endmodule

// ----- hw/rtl/npds_ctrl.sv -----
// ----------------------------------------------------------------------------
// npds_ctrl
// Sequencer: takes points, runs the square root of each minimum at curve end.
// ----------------------------------------------------------------------------
module npds_ctrl
    import npds_pkg::*;
#(
    parameter int NUM_REFS   = 4,
    parameter int MAX_CURVES = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CRV_BITS-1:0] in_curve,
    input  logic                in_last,
    output logic                out_valid,
    input  logic                out_ready,
    output npds_cmd_t           cmd,
    input  npds_sts_t           sts
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_ROOT = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic                last_reg, last_next;
    logic [IDX_BITS-1:0] ref_reg, ref_next;
    logic                in_range;
    logic                fire;

    assign in_range = ({27'd0, in_curve} < 32'(MAX_CURVES));
    assign in_ready = (state_reg == ST_IDLE);
    assign fire     = in_valid && in_ready;
    assign out_valid = (state_reg == ST_OUT);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
            ref_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            ref_reg   <= ref_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        ref_next   = ref_reg;
        cmd        = '0;
        cmd.ref_sel = ref_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (fire && in_range)
                begin
                    cmd.capture = 1'b1;
                    last_next   = in_last;
                    state_next  = ST_UPD;
                end
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                if (last_reg)
                begin
                    ref_next   = '0;
                    state_next = ST_ROOT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ROOT:
            begin
                cmd.root_start = 1'b1;
                state_next     = ST_ACC;
            end
            ST_ACC:
            begin
                if (sts.root_done)
                begin
                    cmd.root_acc = 1'b1;
                    if ({30'd0, ref_reg} == 32'(NUM_REFS - 1) || ref_reg == '1)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        ref_next   = ref_reg + 1'b1;
                        state_next = ST_ROOT;
                    end
                end
                else
                begin
                    cmd.root_step = 1'b1;
                end
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// ----- hw/rtl/npds_dp.sv -----
// ----------------------------------------------------------------------------
// npds_dp
// Distance units, running minima, a bit-serial rounded square root, and the
// prefix sums with their running bests.
// ----------------------------------------------------------------------------
module npds_dp
    import npds_pkg::*;
#(
    parameter int NUM_REFS   = 4,
    parameter int COORD_BITS = 20
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [REG_BITS-1:0] ref_pts [4],
    input  logic [SLOT_BITS-1:0] px,
    input  logic [SLOT_BITS-1:0] py,
    input  logic [SLOT_BITS-1:0] pz,
    input  logic [CRV_BITS-1:0] curve,
    input  npds_cmd_t           cmd,
    output npds_sts_t           sts,
    output logic [SUM_BITS-1:0] sums [4],
    output logic [SUM_BITS-1:0] bests [4],
    output logic [CRV_BITS-1:0] best_idx
);
    localparam int C = COORD_BITS;

    logic signed [C-1:0]   px_reg, py_reg, pz_reg;
    logic [CRV_BITS-1:0]   curve_reg;
    logic [SQ_BITS-1:0]    near_reg [4];
    logic [SQ_BITS-1:0]    sq_dist [4];
    logic [SUM_BITS-1:0]   sum_reg [4];
    logic [SUM_BITS-1:0]   best_reg [4];
    logic [CRV_BITS-1:0]   bidx_reg;
    logic [SQ_BITS:0]      rem_reg;
    logic [SQ_BITS:0]      res_reg;
    logic [SQ_BITS:0]      bit_reg;
    logic [SUM_BITS-1:0]   acc_reg;
    logic [SUM_BITS-1:0]   root_val;
    logic [SUM_BITS-1:0]   acc_base;
    logic [SUM_BITS-1:0]   acc_new;

    // Squared distance to each reference; the magnitude of each axis
    // difference is squared by one multiplier per axis and reference.
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            logic signed [C:0] dx, dy, dz;
            logic [C:0]        ax, ay, az;
            logic [2*C+1:0]    sx, sy, sz;
            dx = {px_reg[C-1], px_reg} - $signed({ref_pts[r][C-1], ref_pts[r][C-1:0]});
            dy = {py_reg[C-1], py_reg}
                 - $signed({ref_pts[r][SLOT_BITS+C-1], ref_pts[r][SLOT_BITS +: C]});
            dz = {pz_reg[C-1], pz_reg}
                 - $signed({ref_pts[r][2*SLOT_BITS+C-1], ref_pts[r][2*SLOT_BITS +: C]});
            ax = dx[C] ? unsigned'(-dx) : unsigned'(dx);
            ay = dy[C] ? unsigned'(-dy) : unsigned'(dy);
            az = dz[C] ? unsigned'(-dz) : unsigned'(dz);
            sx = (2*C+2)'(ax) * (2*C+2)'(ax);
            sy = (2*C+2)'(ay) * (2*C+2)'(ay);
            sz = (2*C+2)'(az) * (2*C+2)'(az);
            sq_dist[r] = SQ_BITS'(sx) + SQ_BITS'(sy) + SQ_BITS'(sz);
        end
    end

    // Rounded integer square root, one result bit per step.
    assign root_val = SUM_BITS'((rem_reg > res_reg) ? res_reg + 1'b1 : res_reg);
    // The first reference starts a fresh prefix sum.
    assign acc_base = (cmd.ref_sel == '0) ? '0 : acc_reg;
    assign acc_new  = acc_base + (({30'd0, cmd.ref_sel} < 32'(NUM_REFS)) ? root_val : '0);
    assign sts.root_done = (bit_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            px_reg    <= px[C-1:0];
            py_reg    <= py[C-1:0];
            pz_reg    <= pz[C-1:0];
            curve_reg <= curve;
        end
        if (cmd.root_start)
        begin
            rem_reg <= {1'b0, near_reg[cmd.ref_sel]};
            res_reg <= '0;
            bit_reg <= (SQ_BITS+1)'(1) << 42;
        end
        else if (cmd.root_step)
        begin
            if (rem_reg >= res_reg + bit_reg)
            begin
                rem_reg <= rem_reg - (res_reg + bit_reg);
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.root_acc)
        begin
            acc_reg              <= acc_new;
            sum_reg[cmd.ref_sel] <= acc_new;
        end
        // Shorter reference lists repeat the last full sum.
        if (cmd.finish)
        begin
            for (int r = 1; r < 4; r++)
            begin
                if (r >= NUM_REFS)
                begin
                    sum_reg[r] <= sum_reg[NUM_REFS-1];
                end
            end
        end
    end

    // Minima and running bests.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 4; r++)
            begin
                near_reg[r] <= NEAR_INIT;
                best_reg[r] <= BEST_INIT;
            end
            bidx_reg <= '0;
        end
        else if (cmd.update)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (r < NUM_REFS && sq_dist[r] < near_reg[r])
                begin
                    near_reg[r] <= sq_dist[r];
                end
            end
        end
        else if (cmd.finish)
        begin
            for (int r = 0; r < 4; r++)
            begin
                near_reg[r] <= NEAR_INIT;
                if (sums[r] < best_reg[r])
                begin
                    best_reg[r] <= sums[r];
                end
            end
            if (sums[3] < best_reg[3])
            begin
                bidx_reg <= curve_reg;
            end
        end
    end

    // Sums as seen at finish include the padding for short reference lists.
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            sums[r] = (r >= NUM_REFS) ? sum_reg[NUM_REFS-1] : sum_reg[r];
        end
    end
    assign bests    = best_reg;
    assign best_idx = bidx_reg;
endmodule

// ----- test/nearest_point_distance_sum_top_tb.sv -----
// ----------------------------------------------------------------------------
// nearest_point_distance_sum_top_tb
// Streams path points through the block and checks every curve-end result
// against a cycle-free predictor of nearest distances, prefix sums and bests.
// ----------------------------------------------------------------------------
module nearest_point_distance_sum_top_tb;
    import npds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_REF_S = 2'd0;
    localparam logic [1:0] REG_REF_A = 2'd1;
    localparam logic [1:0] REG_REF_B = 2'd2;
    localparam logic [1:0] REG_REF_E = 2'd3;
    localparam int DRAIN_CYCLES = 150;
    localparam int STALL_LIMIT  = 20000;

    typedef struct packed {
        logic [SUM_BITS-1:0] sum_four;
        logic [SUM_BITS-1:0] sum_three;
        logic [SUM_BITS-1:0] sum_two;
        logic [SUM_BITS-1:0] sum_one;
        logic [SUM_BITS-1:0] best_four;
        logic [SUM_BITS-1:0] best_three;
        logic [SUM_BITS-1:0] best_two;
        logic [SUM_BITS-1:0] best_one;
        logic [CRV_BITS-1:0] best_curve;
    } curve_result_t;

    logic clk;
    logic rst_n;

    npds_point_if  point();
    npds_result_if result();
    npds_cfg_if    cfg();

    nearest_point_distance_sum_top u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point),
        .result (result),
        .cfg    (cfg)
    );

    // Predictor state.
    logic [REG_BITS-1:0] ref_pt [4];
    logic [SQ_BITS-1:0]  min_sq [4];
    logic [SUM_BITS-1:0] best_sum [4];
    logic [CRV_BITS-1:0] best_crv;

    curve_result_t expected_results[$];
    int error_count;
    int send_idle_pct;
    int stall_pct;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Signed coordinate from a 20-bit slot.
    function automatic longint coord(logic [SLOT_BITS-1:0] v);
        return longint'($signed(v));
    endfunction

    // Square root rounded to nearest, bit by bit.
    function automatic longint unsigned root_round(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        if (v > res)
            res = res + 1;
        return res;
    endfunction

    // Folds one accepted point into the minima; on a curve end, queues the result.
    task automatic track_nearest(logic [19:0] x, logic [19:0] y, logic [19:0] z,
                                 logic [4:0] crv, logic last);
        longint unsigned d;
        longint dx;
        longint dy;
        longint dz;
        longint unsigned acc;
        logic [SUM_BITS-1:0] sums [4];
        curve_result_t r;
        for (int k = 0; k < 4; k++)
        begin
            dx = coord(x) - coord(ref_pt[k][19:0]);
            dy = coord(y) - coord(ref_pt[k][39:20]);
            dz = coord(z) - coord(ref_pt[k][59:40]);
            d = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
            if (d < min_sq[k])
                min_sq[k] = d[SQ_BITS-1:0];
        end
        if (!last)
            return;
        acc = 0;
        for (int k = 0; k < 4; k++)
        begin
            acc = acc + root_round(min_sq[k]);
            sums[k] = acc[SUM_BITS-1:0];
            min_sq[k] = NEAR_INIT;
        end
        if (sums[3] < best_sum[3])
        begin
            best_sum[3] = sums[3];
            best_crv = crv;
        end
        for (int k = 0; k < 3; k++)
        begin
            if (sums[k] < best_sum[k])
                best_sum[k] = sums[k];
        end
        r.sum_four   = sums[3];
        r.sum_three  = sums[2];
        r.sum_two    = sums[1];
        r.sum_one    = sums[0];
        r.best_four  = best_sum[3];
        r.best_three = best_sum[2];
        r.best_two   = best_sum[1];
        r.best_one   = best_sum[0];
        r.best_curve = best_crv;
        expected_results = {expected_results, r};
    endtask

    task automatic report(string what, longint unsigned got, longint unsigned want);
        error_count++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Sends one point, with a random gap before it. Valid stays high after
    // the transfer so that the next point can follow without a gap.
    task automatic send_point(logic [19:0] x, logic [19:0] y, logic [19:0] z,
                              logic [4:0] crv, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            point.valid <= 1'b0;
            @(posedge clk);
        end
        point.valid        <= 1'b1;
        point.point_x      <= x;
        point.point_y      <= y;
        point.point_z      <= z;
        point.curve_number <= crv;
        point.last_point   <= last;
        @(posedge clk);
        while (!point.ready)
            @(posedge clk);
        track_nearest(x, y, z, crv, last);
    endtask

    task automatic wait_idle();
        point.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write; only called while the block is idle.
    task automatic write_ref(logic [1:0] idx, logic [59:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        ref_pt[idx] = value;
    endtask

    task automatic load_refs(logic [59:0] s, logic [59:0] a, logic [59:0] b, logic [59:0] e);
        wait_idle();
        write_ref(REG_REF_S, s);
        write_ref(REG_REF_A, a);
        write_ref(REG_REF_B, b);
        write_ref(REG_REF_E, e);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [59:0] rand_ref();
        return {20'($urandom_range(1048575)), 20'($urandom_range(1048575)),
                20'($urandom_range(1048575))};
    endfunction

    // Extreme coordinates, single-point curves, ties and curve numbers 0 and 31.
    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct = 0;
        load_refs('0, {3{20'h7FFFF}}, {3{20'h80000}}, {20'hAAAAA, 20'h55555, 20'h0F0F0});
        send_point(20'h00000, 20'h00000, 20'h00000, 5'd0, 1'b1);
        send_point(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 5'd31, 1'b1);
        send_point(20'h80000, 20'h80000, 20'h80000, 5'd1, 1'b1);
        send_point(20'h7FFFF, 20'h80000, 20'h7FFFF, 5'd2, 1'b0);
        send_point(20'h80000, 20'h7FFFF, 20'h80000, 5'd2, 1'b1);
        // Same curve again: tie must keep the earlier curve number.
        send_point(20'h00000, 20'h00000, 20'h00000, 5'd21, 1'b1);
        // Curve number changes without a last point: points merge.
        send_point(20'h12345, 20'hFEDCB, 20'h00100, 5'd10, 1'b0);
        send_point(20'h55555, 20'hAAAAA, 20'h0F0F0, 5'd11, 1'b0);
        send_point(20'h00001, 20'hFFFFF, 20'h00000, 5'd31, 1'b1);
        // Pause until every result has come back.
        wait_idle();
        load_refs({3{20'hFFFFF}}, 60'hFFF_FFFF_FFFF_FFFF, {3{20'h00001}}, '0);
        send_point(20'h00000, 20'h00000, 20'h00000, 5'd5, 1'b1);
        send_point(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 5'd6, 1'b0);
        send_point(20'h00001, 20'h00001, 20'h00001, 5'd6, 1'b0);
        send_point(20'h80000, 20'h7FFFF, 20'h00000, 5'd6, 1'b1);
        send_point(20'h7FFFF, 20'h80000, 20'hFFFFF, 5'd16, 1'b1);
    endtask

    // Random curves: mostly points near the references, some anywhere.
    task automatic test_random(int n_points, int idle, int stall);
        int left;
        int len;
        int crv;
        int k;
        logic [19:0] c [3];
        send_idle_pct = idle;
        stall_pct = stall;
        left = n_points;
        while (left > 0)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 6);
            crv = $urandom_range(31);
            for (int i = 0; i < len && left > 0; i++)
            begin
                k = $urandom_range(3);
                for (int a = 0; a < 3; a++)
                begin
                    if ($urandom_range(3) == 0)
                        c[a] = 20'($urandom_range(1048575));
                    else
                        c[a] = ref_pt[k][a*20 +: 20] + 20'($signed($urandom_range(4095)) - 2048);
                end
                left--;
                send_point(c[0], c[1], c[2], 5'(crv), (i == len - 1) || (left == 0));
            end
        end
    endtask

    // Result checking and watchdog.
    always @(posedge clk)
    begin
        curve_result_t w;
        logic moved;
        if (rst_n)
        begin
            moved = (point.valid && point.ready) || (cfg.valid && cfg.ready)
                    || (result.valid && result.ready);
            if (moved)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (result.valid && result.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report("unexpected result", result.sum_four, 0);
                end
                else
                begin
                    w = expected_results.pop_front();
                    if (result.sum_four !== w.sum_four)
                        report("sum_four", result.sum_four, w.sum_four);
                    if (result.sum_three !== w.sum_three)
                        report("sum_three", result.sum_three, w.sum_three);
                    if (result.sum_two !== w.sum_two)
                        report("sum_two", result.sum_two, w.sum_two);
                    if (result.sum_one !== w.sum_one)
                        report("sum_one", result.sum_one, w.sum_one);
                    if (result.best_four !== w.best_four)
                        report("best_four", result.best_four, w.best_four);
                    if (result.best_three !== w.best_three)
                        report("best_three", result.best_three, w.best_three);
                    if (result.best_two !== w.best_two)
                        report("best_two", result.best_two, w.best_two);
                    if (result.best_one !== w.best_one)
                        report("best_one", result.best_one, w.best_one);
                    if (result.best_curve !== w.best_curve)
                        report("best_curve", result.best_curve, w.best_curve);
                end
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout with %0d results outstanding", expected_results.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Receiver stalls at random.
    always @(posedge clk)
    begin
        result.ready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        error_count = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        for (int k = 0; k < 4; k++)
        begin
            ref_pt[k] = '0;
            min_sq[k] = NEAR_INIT;
            best_sum[k] = BEST_INIT;
        end
        best_crv = '0;
        rst_n <= 1'b0;
        point.valid <= 1'b0;
        point.point_x <= '0;
        point.point_y <= '0;
        point.point_z <= '0;
        point.curve_number <= '0;
        point.last_point <= 1'b0;
        cfg.valid <= 1'b0;
        cfg.index <= '0;
        cfg.data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        load_refs(rand_ref(), rand_ref(), rand_ref(), rand_ref());
        test_random(140, 0, 0);
        load_refs(rand_ref(), rand_ref(), rand_ref(), rand_ref());
        test_random(130, 58, 0);
        load_refs('0, rand_ref(), {3{20'h80000}}, rand_ref());
        test_random(130, 0, 58);
        load_refs(rand_ref(), {3{20'h7FFFF}}, rand_ref(), rand_ref());
        test_random(130, 19, 19);

        wait_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
